>>> hdl/tcgr_pkg.sv
// Shared types and constants for the text console glyph renderer.
// Used by the renderer modules apart from tcgr_ram; depends on nothing else.
`default_nettype none

package tcgr_pkg;

  // Font and store geometry.
  localparam int MAX_GLYPH_ROWS = 32;
  localparam int GLYPH_COUNT    = 256;
  localparam int MAX_SCREEN_DIM = 4096;
  localparam int ROW_W          = $clog2(MAX_GLYPH_ROWS);
  localparam int CODE_W         = $clog2(GLYPH_COUNT);
  localparam int STORE_DEPTH    = GLYPH_COUNT * MAX_GLYPH_ROWS;
  localparam int STORE_AW       = $clog2(STORE_DEPTH);

  // Field widths.
  localparam int GH_W    = 6;
  localparam int DIM_W   = 13;
  localparam int COLOR_W = 24;
  localparam int COORD_W = 12;
  localparam int MASK_W  = 8;
  localparam int LEN_W   = 24;
  localparam int COL_W   = 9;
  localparam int ROWC_W  = 12;

  // Configuration port.
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;
  localparam int CFG_IDXW = 3;

  // Register indexes.
  localparam logic [CFG_IDXW-1:0] REG_GLYPH_HEIGHT = 3'd0;
  localparam logic [CFG_IDXW-1:0] REG_SCREEN_W     = 3'd1;
  localparam logic [CFG_IDXW-1:0] REG_SCREEN_H     = 3'd2;
  localparam logic [CFG_IDXW-1:0] REG_FG_COLOR     = 3'd3;
  localparam logic [CFG_IDXW-1:0] REG_BG_COLOR     = 3'd4;

  // Register reset values.
  localparam logic [GH_W-1:0]    GLYPH_HEIGHT_RST = 6'd16;
  localparam logic [DIM_W-1:0]   SCREEN_W_RST     = 13'd1024;
  localparam logic [DIM_W-1:0]   SCREEN_H_RST     = 13'd768;
  localparam logic [COLOR_W-1:0] FG_COLOR_RST     = 24'hf49445;
  localparam logic [COLOR_W-1:0] BG_COLOR_RST     = 24'h180a0a;

  // Request and command kinds.
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_PUT    = 1'b1;
  localparam logic OP_DRAW    = 1'b0;
  localparam logic OP_SCROLL  = 1'b1;

  localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [GH_W-1:0]   MAX_ROWS_GH  = GH_W'(MAX_GLYPH_ROWS);
  localparam logic [DIM_W-1:0]  MAX_DIM_V    = DIM_W'(MAX_SCREEN_DIM);

  // Clamped configuration as seen by the engine.
  typedef struct packed {
    logic [GH_W-1:0]    height;
    logic [DIM_W-1:0]   width_px;
    logic [DIM_W-1:0]   height_px;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic               op_kind;
    logic [COORD_W-1:0] x_px;
    logic [COORD_W-1:0] y_px;
    logic [MASK_W-1:0]  row_mask;
    logic [COLOR_W-1:0] color;
    logic [LEN_W-1:0]   move_src_px;
    logic [LEN_W-1:0]   move_len_px;
    logic               last;
  } result_t;

  // Glyph store read request.
  typedef struct packed {
    logic                re;
    logic [STORE_AW-1:0] addr;
  } rd_req_t;

endpackage

`default_nettype wire

>>> hdl/text_console_glyph_renderer_core.sv
// Text console glyph renderer, top level. A load transfer writes one byte into the glyph store.
// A put transfer of a printable code runs the cursor and scroll arithmetic (ST_CURS, ST_SCHK),
// then one glyph store read and one draw per row, plus a scroll command when the screen scrolls;
// a newline runs the same arithmetic, then only the scroll command when the screen scrolls.
// Reset (synchronous, rst_n low) clears the cursor and restores register defaults;
// the glyph store is not cleared and must be loaded before use.
`default_nettype none

module text_console_glyph_renderer_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Input stream.
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [31:0]                  in_tdata,  // glyph_addr[12:0], glyph_byte[20:13],
                                                       // char_code[28:21], zero[31:29]
  input  wire logic [0:0]                   in_tuser,  // req_type[0]
  // Result stream.
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [103:0]                      out_tdata, // x_px[11:0], y_px[23:12],
                                                       // row_mask[31:24], color[55:32],
                                                       // move_src_px[79:56], move_len_px[103:80]
  output logic [0:0]                        out_tuser, // op_kind[0]
  output logic                              out_tlast,
  // Configuration port.
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [tcgr_pkg::CFG_AW-1:0]  cfg_paddr,
  input  wire logic [tcgr_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic      [tcgr_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                              cfg_pready
);
  import tcgr_pkg::*;

  cfg_t              cfg;
  rd_req_t           rd_req;
  result_t           res;
  logic              in_xfer;
  logic              store_we;
  logic              put_start;
  logic              eng_idle;
  logic [MASK_W-1:0] rd_data;

  assign cfg_pready = 1'b1;
  assign in_tready  = eng_idle;
  assign in_xfer    = in_tvalid & in_tready;
  assign store_we   = in_xfer & (in_tuser[0] == REQ_LOAD);
  assign put_start  = in_xfer & (in_tuser[0] == REQ_PUT);

  // Configuration registers.
  tcgr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // Glyph store: loads write directly, the engine reads one row per cycle while the result stream does not stall.
  tcgr_ram #(
    .WIDTH (MASK_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (in_tdata[STORE_AW-1:0]),
    .wdata (in_tdata[20:13]),
    .re    (rd_req.re),
    .raddr (rd_req.addr),
    .rdata (rd_data)
  );

  // Put sequencer and output register.
  tcgr_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .start      (put_start),
    .start_code (in_tdata[28:21]),
    .idle       (eng_idle),
    .rd_req     (rd_req),
    .rd_data    (rd_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (res)
  );

  // Result packing.
  assign out_tdata = {res.move_len_px, res.move_src_px, res.color,
                      res.row_mask, res.y_px, res.x_px};
  assign out_tuser = res.op_kind;
  assign out_tlast = res.last;

`ifndef NO_ASSERTIONS
  // A put always takes the sequencer out of the idle state.
  a_put_busy: assert property (@(posedge clk) disable iff (!rst_n)
    put_start |=> !in_tready)
    else $error("put transfer did not start the sequencer");

  // A scroll command always closes the run of results of its item.
  a_scroll_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0] == OP_SCROLL) |-> out_tlast)
    else $error("scroll result without last");

  // Loads and glyph row reads never share a cycle.
  a_store_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(store_we && rd_req.re))
    else $error("glyph store written while a row is read");

  // Scroll results carry no draw position or mask.
  a_scroll_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0] == OP_SCROLL) |-> (out_tdata[31:0] == 32'd0))
    else $error("scroll result with draw fields set");
`endif

endmodule

`default_nettype wire

>>> hdl/tcgr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; used for the glyph store.
`default_nettype none

module tcgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/tcgr_cfg.sv
// Configuration registers with an APB-style port and range clamping.
// Depends on tcgr_pkg.
`default_nettype none

module tcgr_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tcgr_pkg::CFG_AW-1:0] paddr,
  input  wire logic [tcgr_pkg::CFG_DW-1:0] pwdata,
  output logic      [tcgr_pkg::CFG_DW-1:0] prdata,
  output tcgr_pkg::cfg_t                   cfg
);
  import tcgr_pkg::*;

  logic [GH_W-1:0]     glyph_height_r;
  logic [DIM_W-1:0]    screen_w_r;
  logic [DIM_W-1:0]    screen_h_r;
  logic [COLOR_W-1:0]  fg_color_r;
  logic [COLOR_W-1:0]  bg_color_r;
  logic                wr_en;
  logic [CFG_IDXW-1:0] idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = paddr[CFG_AW-1:2];

  // Register writes; pready is always high so the access cycle completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_height_r <= GLYPH_HEIGHT_RST;
      screen_w_r     <= SCREEN_W_RST;
      screen_h_r     <= SCREEN_H_RST;
      fg_color_r     <= FG_COLOR_RST;
      bg_color_r     <= BG_COLOR_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_GLYPH_HEIGHT: glyph_height_r <= pwdata[GH_W-1:0];
        REG_SCREEN_W:     screen_w_r     <= pwdata[DIM_W-1:0];
        REG_SCREEN_H:     screen_h_r     <= pwdata[DIM_W-1:0];
        REG_FG_COLOR:     fg_color_r     <= pwdata[COLOR_W-1:0];
        REG_BG_COLOR:     bg_color_r     <= pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (idx)
      REG_GLYPH_HEIGHT: prdata = CFG_DW'(glyph_height_r);
      REG_SCREEN_W:     prdata = CFG_DW'(screen_w_r);
      REG_SCREEN_H:     prdata = CFG_DW'(screen_h_r);
      REG_FG_COLOR:     prdata = CFG_DW'(fg_color_r);
      REG_BG_COLOR:     prdata = CFG_DW'(bg_color_r);
      default:          prdata = '0;
    endcase
  end

  // Clamp to the supported ranges: a zero height counts as one row.
  always_comb begin
    if (glyph_height_r == '0) begin
      cfg.height = GH_W'(1);
    end else if (glyph_height_r > MAX_ROWS_GH) begin
      cfg.height = MAX_ROWS_GH;
    end else begin
      cfg.height = glyph_height_r;
    end
    cfg.width_px  = (screen_w_r > MAX_DIM_V) ? MAX_DIM_V : screen_w_r;
    cfg.height_px = (screen_h_r > MAX_DIM_V) ? MAX_DIM_V : screen_h_r;
    cfg.fg        = fg_color_r;
    cfg.bg        = bg_color_r;
  end

endmodule

`default_nettype wire

>>> hdl/tcgr_engine.sv
// Put sequencer: cursor update, scroll decision, glyph row reads and the
// output register. Depends on tcgr_pkg; reads the glyph store (a tcgr_ram in the top level) through its read port.
`default_nettype none

module tcgr_engine (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire tcgr_pkg::cfg_t              cfg,
  input  wire logic                        start,
  input  wire logic [tcgr_pkg::CODE_W-1:0] start_code,
  output logic                             idle,
  output tcgr_pkg::rd_req_t                rd_req,
  input  wire logic [tcgr_pkg::MASK_W-1:0] rd_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output tcgr_pkg::result_t                out_data
);
  import tcgr_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CURS   = 3'd1;
  localparam logic [2:0] ST_SCHK   = 3'd2;
  localparam logic [2:0] ST_DRAW   = 3'd3;
  localparam logic [2:0] ST_SCROLL = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [COL_W-1:0]    cursor_col_r;
  logic [ROWC_W-1:0]   cursor_row_r;
  logic [CODE_W-1:0]   code_r;
  logic                nl_r;
  logic [COL_W-1:0]    col1_r;
  logic [ROWC_W:0]     row1_r;
  logic [COORD_W-1:0]  x_r;
  logic [COORD_W-1:0]  y0_r;
  logic [LEN_W-1:0]    src_r;
  logic [LEN_W-1:0]    len_r;
  logic                scroll_r;
  logic [ROW_W-1:0]    j_r;
  logic                out_valid_r;
  result_t             out_data_r;

  logic                out_free;
  logic                load_out;
  result_t             out_nxt;
  logic [COL_W:0]      col_inc;
  logic [DIM_W-1:0]    edge_px;
  logic                wrap;
  logic [COL_W-1:0]    col1_nxt;
  logic [ROWC_W:0]     row1_nxt;
  logic [17:0]         y0_full;
  logic [18:0]         src_full;
  logic [DIM_W-1:0]    sh_diff;
  logic [25:0]         len_full;
  logic [ROWC_W:0]     row1_p1;
  logic [19:0]         bottom_px;
  logic                scroll;
  logic [ROWC_W:0]     row_fin;
  logic                last_row;

  assign out_free  = !out_valid_r || out_ready;
  assign idle      = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Cursor advance, taken from the cursor before this character.
  always_comb begin
    col_inc = {1'b0, cursor_col_r} + (COL_W+1)'(1);
    edge_px = {col_inc + (COL_W+1)'(1), 3'b000};
    wrap    = (edge_px >= cfg.width_px);
    if (nl_r || wrap) begin
      col1_nxt = '0;
      row1_nxt = {1'b0, cursor_row_r} + (ROWC_W+1)'(1);
    end else begin
      col1_nxt = col_inc[COL_W-1:0];
      row1_nxt = {1'b0, cursor_row_r};
    end
    y0_full  = cursor_row_r * cfg.height;
    src_full = cfg.width_px * cfg.height;
    sh_diff  = cfg.height_px - DIM_W'(cfg.height);
    len_full = cfg.width_px * sh_diff;
  end

  // Scroll decision on the advanced cursor row.
  always_comb begin
    row1_p1   = row1_r + (ROWC_W+1)'(1);
    bottom_px = 20'(row1_p1 * cfg.height);
    scroll    = (bottom_px >= 20'(cfg.height_px));
    if (scroll && row1_r != '0) begin
      row_fin = row1_r - (ROWC_W+1)'(1);
    end else begin
      row_fin = row1_r;
    end
  end

  assign last_row = ({1'b0, j_r} == cfg.height - GH_W'(1));

  // Sequencer next state, glyph reads and output loading.
  always_comb begin
    state_nxt   = state_r;
    rd_req.re   = 1'b0;
    rd_req.addr = {code_r, ROW_W'(0)};
    load_out    = 1'b0;
    out_nxt     = '0;
    out_nxt.color = cfg.fg;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CURS;
        end
      end
      ST_CURS: begin
        state_nxt = ST_SCHK;
      end
      ST_SCHK: begin
        if (nl_r) begin
          state_nxt = scroll ? ST_SCROLL : ST_IDLE;
        end else begin
          rd_req.re = 1'b1;
          state_nxt = ST_DRAW;
        end
      end
      ST_DRAW: begin
        out_nxt.op_kind  = OP_DRAW;
        out_nxt.x_px     = x_r;
        out_nxt.y_px     = y0_r + COORD_W'(j_r);
        out_nxt.row_mask = rd_data;
        out_nxt.last     = last_row && !scroll_r;
        if (out_free) begin
          load_out = 1'b1;
          if (last_row) begin
            state_nxt = scroll_r ? ST_SCROLL : ST_IDLE;
          end else begin
            rd_req.re   = 1'b1;
            rd_req.addr = {code_r, j_r + ROW_W'(1)};
          end
        end
      end
      ST_SCROLL: begin
        out_nxt.op_kind     = OP_SCROLL;
        out_nxt.color       = cfg.bg;
        out_nxt.move_src_px = src_r;
        out_nxt.move_len_px = len_r;
        out_nxt.last        = 1'b1;
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cursor_col_r <= '0;
      cursor_row_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_SCHK) begin
        cursor_col_r <= col1_r;
        cursor_row_r <= row_fin[ROWC_W-1:0];
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      code_r <= start_code;
      nl_r   <= (start_code == NEWLINE_CODE);
    end
    if (state_r == ST_CURS) begin
      col1_r <= col1_nxt;
      row1_r <= row1_nxt;
      x_r    <= {cursor_col_r, 3'b000};
      y0_r   <= y0_full[COORD_W-1:0];
      src_r  <= LEN_W'(src_full);
      len_r  <= (cfg.height_px > DIM_W'(cfg.height)) ? len_full[LEN_W-1:0] : '0;
    end
    if (state_r == ST_SCHK) begin
      scroll_r <= scroll;
      j_r      <= '0;
    end else if (state_r == ST_DRAW && out_free && !last_row) begin
      j_r <= j_r + ROW_W'(1);
    end
    if (load_out) begin
      out_data_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire
